>>> src/dra_pkg.sv
// Package: shared types and constants for the DNS A-record extractor.
package dra_pkg;

  // Default message buffer size in bytes
  localparam int DRA_MAX_MSG_BYTES = 512;

  // Header layout and record field lengths
  localparam int HDR_LEN     = 12;
  localparam int QFIXED_LEN  = 4;
  localparam int AFIXED_LEN  = 10;
  localparam int LABEL_MAX   = 63;

  // Bit masks on header and name bytes
  localparam logic [7:0] PTR_MASK   = 8'hC0;
  localparam logic [7:0] RESP_MASK  = 8'h80;
  localparam logic [7:0] RCODE_MASK = 8'h0F;

  // Record type and data length of an IPv4 address record
  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] A_RDLEN  = 16'd4;

  // Parse phases
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QPTR   = 4'd2,
    PH_QFIXED = 4'd3,
    PH_ANAME  = 4'd4,
    PH_APTR   = 4'd5,
    PH_AFIXED = 4'd6,
    PH_ASKIP  = 4'd7,
    PH_ACAP   = 4'd8,
    PH_IDLE   = 4'd9,
    PH_QBAD   = 4'd10
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_ID        = 3'd2,
    ST_NOT_RESP  = 3'd3,
    ST_RCODE     = 3'd4,
    ST_BAD_QUEST = 3'd5,
    ST_NO_RECORD = 3'd6
  } status_e;

  // Input word: one message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word: one per message
  typedef struct packed {
    logic        found;
    logic [31:0] ipv4_addr;
    logic [2:0]  status;
  } out_word_t;

endpackage

>>> src/dra_parser.sv
// Byte parser: message state registers and per-byte next-state logic.
module dra_parser #(
  parameter int MAX_MSG_BYTES = dra_pkg::DRA_MAX_MSG_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               take_i,
  input  dra_pkg::in_word_t  word_i,
  output logic               res_valid_o,
  output dra_pkg::out_word_t res_word_o
);

  localparam int CntW = $clog2(MAX_MSG_BYTES + 1);

  typedef enum logic [1:0] {NM_MORE, NM_END, NM_PTR, NM_BAD} name_e;

  logic [15:0]      expected_id_q;
  logic [CntW-1:0]  count_q, count_d;
  dra_pkg::phase_e  phase_q, phase_d;
  dra_pkg::status_e hdr_err_q, hdr_err_d;
  logic [15:0]      quest_q, quest_d;
  logic [15:0]      ans_q, ans_d;
  logic [7:0]       label_q, label_d;
  logic [3:0]       field_q, field_d;
  logic [15:0]      rtype_q, rtype_d;
  logic [15:0]      rdlen_q, rdlen_d;
  logic [31:0]      addr_q, addr_d;
  logic             found_q, found_d;

  logic             in_buf;
  logic             go_next;
  name_e            nm_res;
  logic [7:0]       nm_label;
  logic [7:0]       b;
  dra_pkg::status_e status;

  assign b      = word_i.data_byte;
  assign in_buf = (count_q < CntW'(MAX_MSG_BYTES));

  // Name byte decode: label skip, end, pointer or bad length
  always_comb begin
    nm_label = label_q;
    nm_res   = NM_MORE;
    if (label_q != 8'd0) begin
      nm_label = label_q - 8'd1;
    end else if (b == 8'd0) begin
      nm_res = NM_END;
    end else if ((b & dra_pkg::PTR_MASK) == dra_pkg::PTR_MASK) begin
      nm_res = NM_PTR;
    end else if (b > 8'(dra_pkg::LABEL_MAX)) begin
      nm_res = NM_BAD;
    end else begin
      nm_label = b;
    end
  end

  // Next message state for one byte
  always_comb begin
    count_d   = count_q;
    phase_d   = phase_q;
    hdr_err_d = hdr_err_q;
    quest_d   = quest_q;
    ans_d     = ans_q;
    label_d   = label_q;
    field_d   = field_q;
    rtype_d   = rtype_q;
    rdlen_d   = rdlen_q;
    addr_d    = addr_q;
    found_d   = found_q;
    go_next   = 1'b0;

    if (in_buf) begin
      count_d = count_q + CntW'(1);
      unique case (phase_q)
        dra_pkg::PH_HEADER: begin
          if (count_q == CntW'(0) && b != expected_id_q[15:8] &&
              hdr_err_d == dra_pkg::ST_OK) begin
            hdr_err_d = dra_pkg::ST_ID;
          end
          if (count_q == CntW'(1) && b != expected_id_q[7:0] &&
              hdr_err_d == dra_pkg::ST_OK) begin
            hdr_err_d = dra_pkg::ST_ID;
          end
          if (count_q == CntW'(2) && (b & dra_pkg::RESP_MASK) == 8'd0 &&
              hdr_err_d == dra_pkg::ST_OK) begin
            hdr_err_d = dra_pkg::ST_NOT_RESP;
          end
          if (count_q == CntW'(3) && (b & dra_pkg::RCODE_MASK) != 8'd0 &&
              hdr_err_d == dra_pkg::ST_OK) begin
            hdr_err_d = dra_pkg::ST_RCODE;
          end
          if (count_q == CntW'(4) || count_q == CntW'(5)) begin
            quest_d = {quest_q[7:0], b};
          end
          if (count_q == CntW'(6) || count_q == CntW'(7)) begin
            ans_d = {ans_q[7:0], b};
          end
          if (count_q == CntW'(dra_pkg::HDR_LEN - 1)) begin
            if (hdr_err_d != dra_pkg::ST_OK) begin
              phase_d = dra_pkg::PH_IDLE;
            end else if (quest_d != 16'd0) begin
              label_d = 8'd0;
              phase_d = dra_pkg::PH_QNAME;
            end else begin
              go_next = 1'b1;
            end
          end
        end
        dra_pkg::PH_QNAME: begin
          label_d = nm_label;
          unique case (nm_res)
            NM_END: begin
              field_d = 4'd0;
              phase_d = dra_pkg::PH_QFIXED;
            end
            NM_PTR:  phase_d = dra_pkg::PH_QPTR;
            NM_BAD:  phase_d = dra_pkg::PH_QBAD;
            default: ;
          endcase
        end
        dra_pkg::PH_QPTR: begin
          field_d = 4'd0;
          phase_d = dra_pkg::PH_QFIXED;
        end
        dra_pkg::PH_QFIXED: begin
          field_d = field_q + 4'd1;
          if (field_d >= 4'(dra_pkg::QFIXED_LEN)) begin
            field_d = 4'd0;
            quest_d = quest_q - 16'd1;
            if (quest_d == 16'd0) begin
              go_next = 1'b1;
            end else begin
              label_d = 8'd0;
              phase_d = dra_pkg::PH_QNAME;
            end
          end
        end
        dra_pkg::PH_ANAME: begin
          label_d = nm_label;
          unique case (nm_res)
            NM_END: begin
              field_d = 4'd0;
              phase_d = dra_pkg::PH_AFIXED;
            end
            NM_PTR:  phase_d = dra_pkg::PH_APTR;
            NM_BAD:  phase_d = dra_pkg::PH_IDLE;
            default: ;
          endcase
        end
        dra_pkg::PH_APTR: begin
          field_d = 4'd0;
          phase_d = dra_pkg::PH_AFIXED;
        end
        dra_pkg::PH_AFIXED: begin
          // type in bytes 0-1, data length in bytes 8-9
          if (field_q < 4'd2) begin
            rtype_d = {rtype_q[7:0], b};
          end else if (field_q >= 4'd8) begin
            rdlen_d = {rdlen_q[7:0], b};
          end
          field_d = field_q + 4'd1;
          if (field_d >= 4'(dra_pkg::AFIXED_LEN)) begin
            ans_d = ans_q - 16'd1;
            if (rtype_d == dra_pkg::TYPE_A && rdlen_d == dra_pkg::A_RDLEN) begin
              addr_d  = 32'd0;
              phase_d = dra_pkg::PH_ACAP;
            end else if (rdlen_d == 16'd0) begin
              go_next = 1'b1;
            end else begin
              phase_d = dra_pkg::PH_ASKIP;
            end
          end
        end
        dra_pkg::PH_ASKIP: begin
          rdlen_d = rdlen_q - 16'd1;
          if (rdlen_d == 16'd0) begin
            go_next = 1'b1;
          end
        end
        dra_pkg::PH_ACAP: begin
          addr_d  = {addr_q[23:0], b};
          rdlen_d = rdlen_q - 16'd1;
          if (rdlen_d == 16'd0) begin
            found_d = 1'b1;
            phase_d = dra_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase

      // start the next answer record, or stop when none is left
      if (go_next) begin
        label_d = 8'd0;
        field_d = 4'd0;
        phase_d = (ans_d == 16'd0) ? dra_pkg::PH_IDLE : dra_pkg::PH_ANAME;
      end
    end
  end

  // Result status from the state after this byte
  always_comb begin
    if (count_d < CntW'(dra_pkg::HDR_LEN)) begin
      status = dra_pkg::ST_SHORT;
    end else if (hdr_err_d != dra_pkg::ST_OK) begin
      status = hdr_err_d;
    end else if (phase_d == dra_pkg::PH_QNAME || phase_d == dra_pkg::PH_QPTR ||
                 phase_d == dra_pkg::PH_QFIXED || phase_d == dra_pkg::PH_QBAD) begin
      status = dra_pkg::ST_BAD_QUEST;
    end else begin
      status = found_d ? dra_pkg::ST_OK : dra_pkg::ST_NO_RECORD;
    end
  end

  assign res_valid_o          = take_i && word_i.last_byte;
  assign res_word_o.found     = found_d && (status == dra_pkg::ST_OK);
  assign res_word_o.ipv4_addr = res_word_o.found ? addr_d : 32'd0;
  assign res_word_o.status    = status;

  // Expected transaction id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= 16'd0;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  // Message state; cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      phase_q   <= dra_pkg::PH_HEADER;
      hdr_err_q <= dra_pkg::ST_OK;
      quest_q   <= 16'd0;
      ans_q     <= 16'd0;
      label_q   <= 8'd0;
      field_q   <= 4'd0;
      rtype_q   <= 16'd0;
      rdlen_q   <= 16'd0;
      addr_q    <= 32'd0;
      found_q   <= 1'b0;
    end else if (take_i) begin
      if (word_i.last_byte) begin
        count_q   <= '0;
        phase_q   <= dra_pkg::PH_HEADER;
        hdr_err_q <= dra_pkg::ST_OK;
        quest_q   <= 16'd0;
        ans_q     <= 16'd0;
        label_q   <= 8'd0;
        field_q   <= 4'd0;
        rtype_q   <= 16'd0;
        rdlen_q   <= 16'd0;
        addr_q    <= 32'd0;
        found_q   <= 1'b0;
      end else begin
        count_q   <= count_d;
        phase_q   <= phase_d;
        hdr_err_q <= hdr_err_d;
        quest_q   <= quest_d;
        ans_q     <= ans_d;
        label_q   <= label_d;
        field_q   <= field_d;
        rtype_q   <= rtype_d;
        rdlen_q   <= rdlen_d;
        addr_q    <= addr_d;
        found_q   <= found_d;
      end
    end
  end

endmodule

>>> src/dra_out_reg.sv
// Result register: holds one result word until downstream takes it.
module dra_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dra_pkg::out_word_t word_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output dra_pkg::out_word_t out_word_o,
  output logic               full_o
);

  logic               valid_q, valid_d;
  dra_pkg::out_word_t word_q;

  // stays full only while the held word is stalled
  assign full_o  = valid_q && out_stall_i;
  assign valid_d = load_i || full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> src/dns_response_a_record_extractor.sv
// Top level of the DNS response A-record extractor.
// Takes a DNS response, one byte per word and per unstalled clock, and after
// the byte flagged last delivers one result word (found flag, IPv4 address,
// status) on the following cycle from a result register. The only stall
// source is that register: input stalls while a result waits and the output
// side stalls. Write expected_id before each response; bytes past
// MAX_MSG_BYTES are dropped, but a last flag on them still ends the message.
module dns_response_a_record_extractor #(
  parameter int MAX_MSG_BYTES = dra_pkg::DRA_MAX_MSG_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dra_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dra_pkg::out_word_t out_word_o
);

  logic               take;
  logic               res_valid;
  dra_pkg::out_word_t res_word;
  logic               full;

  // input handshake
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  dra_parser #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .word_i      (in_word_i),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  dra_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .word_i      (res_word),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .full_o      (full)
  );

endmodule

>>> src/dra_checker.sv
// Port-level checker for the DNS A-record extractor, with its bind.
module dra_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dra_pkg::out_word_t out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // found only with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |-> out_word_o.status == dra_pkg::ST_OK)
    else $error("found with error status");

  // no address without a found record, and ok implies found
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |->
      out_word_o.ipv4_addr == 32'd0 && out_word_o.status != dra_pkg::ST_OK)
    else $error("address or ok status without a found record");

endmodule

bind dns_response_a_record_extractor dra_port_checker u_dra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
